// ----- rtl/core/paletted_packed_block_store_defines.svh -----
// Assertion macros shared by the paletted packed block store RTL.
`ifndef PALETTED_PACKED_BLOCK_STORE_DEFINES_SVH
`define PALETTED_PACKED_BLOCK_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk while rst_n is high.
`define PPBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define PPBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPBS_ASSERT(lbl, prop, msg)
`define PPBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/ppbs_pkg.sv -----
// Package with the shared types and constants of the paletted packed block store.
`timescale 1ns / 1ps
`default_nettype none
package ppbs_pkg;

  localparam int WORD_BITS    = 64;
  localparam int OFF_W        = 6;
  localparam int BW_BITS      = 5;
  localparam int DIRECT_FROM  = 9;
  localparam int DEFAULT_BITS = 4;

  localparam logic [2:0] MODE_GET    = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_LOAD   = 3'd2;
  localparam logic [2:0] MODE_APPEND = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_BIT,
    S_PAL_INIT,
    S_PAL_SCAN,
    S_RD_LO,
    S_RD_HI,
    S_FIELD,
    S_PAL_READ,
    S_WR_HI,
    S_DONE
  } ppbs_state_t;

  typedef struct packed {
    logic [OFF_W-1:0]   off;
    logic [BW_BITS-1:0] nbits;
  } ppbs_field_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/ppbs_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ppbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 896,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/ppbs_field.sv -----
// Field extract and insert over a pair of 64-bit packed data words.
`timescale 1ns / 1ps
`default_nettype none
module ppbs_field #(
  parameter int MAX_BITS = 14
) (
  input  ppbs_pkg::ppbs_field_ctl_t           ctl,
  input  logic [ppbs_pkg::WORD_BITS-1:0]      lo_word,
  input  logic [ppbs_pkg::WORD_BITS-1:0]      hi_word,
  input  logic [MAX_BITS-1:0]                 ins_val,
  output logic [MAX_BITS-1:0]                 fld_value,
  output logic [ppbs_pkg::WORD_BITS-1:0]      new_lo,
  output logic [ppbs_pkg::WORD_BITS-1:0]      new_hi,
  output logic                                straddle
);
  import ppbs_pkg::*;

  localparam int PAIR_W = 2 * WORD_BITS;

  logic [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0] lane_mask;
  logic [PAIR_W-1:0] ins_bits;
  logic [PAIR_W-1:0] merged;

  assign pair      = {hi_word, lo_word};
  assign lane_mask = ((PAIR_W'(1) << ctl.nbits) - PAIR_W'(1)) << ctl.off;
  assign ins_bits  = (PAIR_W'(ins_val) << ctl.off) & lane_mask;
  assign merged    = (pair & ~lane_mask) | ins_bits;

  // The field sits in the low bits once the pair is shifted down by the offset.
  assign fld_value = MAX_BITS'((pair & lane_mask) >> ctl.off);
  assign new_lo    = merged[WORD_BITS-1:0];
  assign new_hi    = merged[PAIR_W-1:WORD_BITS];
  assign straddle  = (7'(ctl.off) + 7'(ctl.nbits)) > 7'(WORD_BITS);

endmodule
`default_nettype wire

// ----- rtl/core/paletted_packed_block_store.sv -----
// Top level of the paletted packed block store: control, palette search and data RMW.
//
// Channel  Direction  Beat taken when            Payload
// in       input      start high and busy low    in_mode, in_pos_x/y/z, in_block_id,
//                                                in_word_index, in_word_value,
//                                                in_palette_value
// out      output     out_valid high (1 cycle)   out_result_id, out_status
// cfg      input      cfg_we high                cfg_wdata (bits_per_block)
//
// One beat is worked on at a time; a new beat is taken only once the block is back in
// idle. Load, palette append, no-op and out-of-range beats go straight to the done state.
// A direct get reads two data words and extracts the field; a palette get then reads the
// palette RAM when the field names a valid entry (two data RAM reads, then one palette
// RAM read) and skips that read when it does not. A direct set writes one word back, and
// a second when the field straddles two words (the second write-back uses the single
// write port). A palette set compares one palette entry per cycle through the palette
// RAM read port, after seeding entry 0 on an empty palette. A set refused for a full
// palette ends right after the search. A clear zeroes the DATA_WORDS data words (896 by
// default), one data word per cycle. After reset the same pass zeroes the data RAM while
// busy stays high; configuration writes are taken during that pass as at any time.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "paletted_packed_block_store_defines.svh"
module paletted_packed_block_store #(
  parameter int EDGE          = 16,
  parameter int MAX_BITS      = 14,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic signed [5:0] in_pos_x,
  input  logic signed [5:0] in_pos_y,
  input  logic signed [5:0] in_pos_z,
  input  logic [15:0]       in_block_id,
  input  logic [9:0]        in_word_index,
  input  logic [63:0]       in_word_value,
  input  logic [15:0]       in_palette_value,
  output logic              out_valid,
  output logic [15:0]       out_result_id,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import ppbs_pkg::*;

  localparam int CELLS      = EDGE * EDGE * EDGE;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int DATA_WORDS = (CELLS * MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int DW_AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int BIT_W      = DW_AW + OFF_W;
  localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
  localparam int CNT_W      = $clog2(PALETTE_DEPTH + 1);

  // Control registers.
  ppbs_state_t        state_r, state_nxt;
  logic [3:0]         bpb_r, bpb_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_i_r, scan_i_nxt;
  logic               pend_r, pend_nxt;
  logic [DW_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic               clr_cmd_r, clr_cmd_nxt;

  // Payload registers of the beat in flight.
  logic [2:0]          mode_r, mode_nxt;
  logic [15:0]         id_r, id_nxt;
  logic [BW_BITS-1:0]  b_r, b_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [DW_AW-1:0]    w_r, w_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [63:0]         lo_r, lo_nxt;
  logic [63:0]         new_hi_r, new_hi_nxt;
  logic [MAX_BITS-1:0] val_r, val_nxt;
  logic [15:0]         res_id_r, res_id_nxt;
  logic [1:0]          res_st_r, res_st_nxt;

  // Memory ports.
  logic               d_we;
  logic [DW_AW-1:0]   d_waddr;
  logic [63:0]        d_wdata;
  logic [DW_AW-1:0]   d_raddr;
  logic [63:0]        d_rdata;
  logic               p_we;
  logic [PAL_AW-1:0]  p_waddr;
  logic [15:0]        p_wdata;
  logic [PAL_AW-1:0]  p_raddr;
  logic [15:0]        p_rdata;

  // Field unit.
  ppbs_field_ctl_t     fctl;
  logic [63:0]         hi_in;
  logic [MAX_BITS-1:0] fld_value;
  logic [63:0]         new_lo;
  logic [63:0]         new_hi;
  logic                straddle;

  // Decode helpers.
  logic                 accept;
  logic                 x_ok, y_ok, z_ok, in_inrange;
  logic [IDX_W-1:0]     in_idx;
  logic [BW_BITS-1:0]   eff_b;
  logic                 direct;
  logic [DIRECT_FROM-1:0] cap_sh;
  logic [CNT_W-1:0]     cap;
  logic [CNT_W-1:0]     found_idx;
  logic                 scan_hit, scan_end;
  logic                 field_mapped;
  logic                 load_ok, append_ok;
  logic [BIT_W-1:0]     bit_pos;
  logic [DW_AW-1:0]     w_hi;

  // The data words live in one RAM, the palette ids in another. Both read through a
  // registered port, so every access is an address cycle followed by a data cycle.
  ppbs_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DATA_WORDS)
  ) u_data_ram (
    .clk    (clk),
    .wr_en  (d_we),
    .wr_addr(d_waddr),
    .wr_data(d_wdata),
    .rd_addr(d_raddr),
    .rd_data(d_rdata)
  );

  ppbs_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_DEPTH)
  ) u_pal_ram (
    .clk    (clk),
    .wr_en  (p_we),
    .wr_addr(p_waddr),
    .wr_data(p_wdata),
    .rd_addr(p_raddr),
    .rd_data(p_rdata)
  );

  // The field unit sees the first word from a register and the second word straight
  // from the RAM output, so extract and insert both happen in the field cycle.
  assign fctl.off   = off_r;
  assign fctl.nbits = b_r;
  assign hi_in      = straddle ? d_rdata : '0;

  ppbs_field #(
    .MAX_BITS(MAX_BITS)
  ) u_field (
    .ctl      (fctl),
    .lo_word  (lo_r),
    .hi_word  (hi_in),
    .ins_val  (val_r),
    .fld_value(fld_value),
    .new_lo   (new_lo),
    .new_hi   (new_hi),
    .straddle (straddle)
  );

  assign accept = start && (state_r == S_IDLE);

  // A coordinate is in range when it is not negative and below the cube edge.
  assign x_ok       = !in_pos_x[5] && (32'(in_pos_x[5:0]) < EDGE);
  assign y_ok       = !in_pos_y[5] && (32'(in_pos_y[5:0]) < EDGE);
  assign z_ok       = !in_pos_z[5] && (32'(in_pos_z[5:0]) < EDGE);
  assign in_inrange = x_ok && y_ok && z_ok;
  assign in_idx     = IDX_W'(32'(in_pos_y[5:0]) * 32'(EDGE * EDGE)
                           + 32'(in_pos_z[5:0]) * 32'(EDGE)
                           + 32'(in_pos_x[5:0]));

  // Effective field width: zero means the default width, and the register is clamped
  // to the widest field that the data RAM was sized for.
  always_comb begin
    priority if (bpb_r == 4'd0) begin
      eff_b = BW_BITS'(DEFAULT_BITS);
    end else if (32'(bpb_r) > MAX_BITS) begin
      eff_b = BW_BITS'(MAX_BITS);
    end else begin
      eff_b = BW_BITS'(bpb_r);
    end
  end

  assign direct = (32'(b_r) >= DIRECT_FROM);

  // Palette capacity is the smaller of the palette depth and the number of codes the
  // field can hold. It only matters in palette mode, where the width is at most eight.
  assign cap_sh = DIRECT_FROM'(1) << b_r;
  assign cap    = (32'(cap_sh) > PALETTE_DEPTH) ? CNT_W'(PALETTE_DEPTH) : CNT_W'(cap_sh);

  // The search issues one palette read per cycle and compares the entry that returns
  // from the registered read port, so the pending entry is always scan_i_r - 1.
  assign found_idx = scan_i_r - CNT_W'(1);
  assign scan_hit  = pend_r && (p_rdata == id_r);
  assign scan_end  = !scan_hit && (scan_i_r >= count_r);

  assign field_mapped = (32'(fld_value) < 32'(count_r));
  assign load_ok      = (32'(in_word_index) < DATA_WORDS);
  assign append_ok    = (32'(count_r) < PALETTE_DEPTH);

  assign bit_pos = BIT_W'(idx_r) * BIT_W'(b_r);
  assign w_hi    = w_r + DW_AW'(1);

  assign bpb_nxt = cfg_we ? cfg_wdata : bpb_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_GET, MODE_SET: state_nxt = in_inrange ? S_BIT : S_DONE;
            MODE_CLEAR:         state_nxt = S_CLEAR;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr_r == DW_AW'(DATA_WORDS - 1)) begin
          state_nxt = clr_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_BIT: begin
        if ((mode_r == MODE_SET) && !direct) begin
          state_nxt = (count_r == '0) ? S_PAL_INIT : S_PAL_SCAN;
        end else begin
          state_nxt = S_RD_LO;
        end
      end
      S_PAL_INIT: state_nxt = S_PAL_SCAN;
      S_PAL_SCAN: begin
        if (scan_hit) begin
          state_nxt = (found_idx < cap) ? S_RD_LO : S_DONE;
        end else if (scan_end) begin
          state_nxt = (count_r < cap) ? S_RD_LO : S_DONE;
        end
      end
      S_RD_LO: state_nxt = S_RD_HI;
      S_RD_HI: state_nxt = S_FIELD;
      S_FIELD: begin
        if (mode_r == MODE_GET) begin
          state_nxt = (!direct && field_mapped) ? S_PAL_READ : S_DONE;
        end else begin
          state_nxt = straddle ? S_WR_HI : S_DONE;
        end
      end
      S_PAL_READ: state_nxt = S_DONE;
      S_WR_HI:    state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory controls and register updates.
  always_comb begin
    mode_nxt     = mode_r;
    id_nxt       = id_r;
    b_nxt        = b_r;
    idx_nxt      = idx_r;
    w_nxt        = w_r;
    off_nxt      = off_r;
    lo_nxt       = lo_r;
    new_hi_nxt   = new_hi_r;
    val_nxt      = val_r;
    res_id_nxt   = res_id_r;
    res_st_nxt   = res_st_r;
    count_nxt    = count_r;
    scan_i_nxt   = scan_i_r;
    pend_nxt     = pend_r;
    clr_addr_nxt = clr_addr_r;
    clr_cmd_nxt  = clr_cmd_r;
    d_we         = 1'b0;
    d_waddr      = w_r;
    d_wdata      = new_lo;
    d_raddr      = w_r;
    p_we         = 1'b0;
    p_waddr      = PAL_AW'(count_r);
    p_wdata      = id_r;
    p_raddr      = PAL_AW'(scan_i_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_mode;
          id_nxt     = in_block_id;
          b_nxt      = eff_b;
          idx_nxt    = in_idx;
          res_id_nxt = '0;
          res_st_nxt = ST_OK;
          scan_i_nxt = '0;
          pend_nxt   = 1'b0;
          unique case (in_mode)
            MODE_GET, MODE_SET: begin
              if (!in_inrange) begin
                res_st_nxt = ST_RANGE;
              end
            end
            MODE_LOAD: begin
              if (load_ok) begin
                d_we    = 1'b1;
                d_waddr = DW_AW'(in_word_index);
                d_wdata = in_word_value;
              end else begin
                res_st_nxt = ST_RANGE;
              end
            end
            MODE_APPEND: begin
              if (append_ok) begin
                p_we      = 1'b1;
                p_wdata   = in_palette_value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            MODE_CLEAR: begin
              count_nxt    = '0;
              clr_addr_nxt = '0;
              clr_cmd_nxt  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        d_we         = 1'b1;
        d_waddr      = clr_addr_r;
        d_wdata      = '0;
        clr_addr_nxt = clr_addr_r + DW_AW'(1);
      end
      S_BIT: begin
        w_nxt   = bit_pos[BIT_W-1:OFF_W];
        off_nxt = bit_pos[OFF_W-1:0];
        val_nxt = MAX_BITS'(id_r);
      end
      S_PAL_INIT: begin
        // An empty palette first gets id 0 at entry 0 so that zero fields keep reading 0.
        p_we      = 1'b1;
        p_waddr   = '0;
        p_wdata   = '0;
        count_nxt = CNT_W'(1);
      end
      S_PAL_SCAN: begin
        if (scan_hit) begin
          if (found_idx < cap) begin
            val_nxt = MAX_BITS'(found_idx);
          end else begin
            res_st_nxt = ST_FULL;
          end
        end else if (scan_end) begin
          if (count_r < cap) begin
            p_we      = 1'b1;
            val_nxt   = MAX_BITS'(count_r);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            res_st_nxt = ST_FULL;
          end
        end else begin
          scan_i_nxt = scan_i_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end
      end
      S_RD_LO: begin
        d_raddr = w_r;
      end
      S_RD_HI: begin
        d_raddr = w_hi;
        lo_nxt  = d_rdata;
      end
      S_FIELD: begin
        if (mode_r == MODE_GET) begin
          if (direct) begin
            res_id_nxt = 16'(fld_value);
          end else begin
            p_raddr = PAL_AW'(fld_value);
          end
        end else begin
          d_we       = 1'b1;
          d_waddr    = w_r;
          d_wdata    = new_lo;
          new_hi_nxt = new_hi;
        end
      end
      S_PAL_READ: begin
        res_id_nxt = p_rdata;
      end
      S_WR_HI: begin
        d_we    = 1'b1;
        d_waddr = w_hi;
        d_wdata = new_hi_r;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      bpb_r      <= 4'(DEFAULT_BITS);
      count_r    <= '0;
      scan_i_r   <= '0;
      pend_r     <= 1'b0;
      clr_addr_r <= '0;
      clr_cmd_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bpb_r      <= bpb_nxt;
      count_r    <= count_nxt;
      scan_i_r   <= scan_i_nxt;
      pend_r     <= pend_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_cmd_r  <= clr_cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    id_r     <= id_nxt;
    b_r      <= b_nxt;
    idx_r    <= idx_nxt;
    w_r      <= w_nxt;
    off_r    <= off_nxt;
    lo_r     <= lo_nxt;
    new_hi_r <= new_hi_nxt;
    val_r    <= val_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
  end

  // The result beat is shown for the single cycle spent in the done state.
  assign busy          = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_DONE);
  assign out_result_id = res_id_r;
  assign out_status    = res_st_r;

  `PPBS_ASSERT_ALWAYS(a_reset_starts_clear, !rst_n |=> busy, "reset did not start the clear pass")
  `PPBS_ASSERT(a_result_single, out_valid |=> !out_valid, "result beat held longer than one cycle")
  `PPBS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `PPBS_ASSERT(a_pal_write_count, p_we |=> count_r == $past(count_r) + 1'b1, "no count step")
  `PPBS_ASSERT(a_count_bound, (32'(count_r) <= PALETTE_DEPTH), "palette count beyond depth")

endmodule
`default_nettype wire

// ----- test/paletted_packed_block_store_test.sv -----
// Self-checking testbench for the paletted packed block store: directed rows, then random phases.
`timescale 1ns / 1ps
module paletted_packed_block_store_test;
  import ppbs_pkg::*;

  // Geometry of the instance; these match the defaults of the block.
  localparam int EDGE          = 16;
  localparam int MAX_BITS      = 14;
  localparam int PALETTE_DEPTH = 256;
  localparam int DATA_WORDS    = (EDGE * EDGE * EDGE * MAX_BITS + WORD_BITS - 1) / WORD_BITS;

  // Modes 5 to 7 have no meaning and must answer as a no-op.
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int MAX_GAP         = 12;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int DRAIN_CYCLES    = 16;
  // The slowest beat is a clear; the budget covers every beat being one, plus the
  // clearing pass after reset, and then four times that.
  localparam int BEAT_BUDGET = 1600;
  localparam int CYCLE_LIMIT = 4 * (DATA_WORDS + BEAT_BUDGET * (DATA_WORDS + MAX_GAP + 6));

  // Field widths of the random phases, first phase leftmost. Width 8 is the phase
  // that fills the palette to its depth.
  localparam logic [47:0] PHASE_WIDTHS = {4'd8, 4'd2, 4'd9, 4'd14, 4'd0, 4'd12,
                                          4'd1, 4'd5, 4'd15, 4'd7, 4'd3, 4'd6};
  localparam int PHASES = 12;

  typedef struct {
    logic [2:0]        mode;
    logic signed [5:0] x;
    logic signed [5:0] y;
    logic signed [5:0] z;
    logic [15:0]       block_id;
    logic [9:0]        word_index;
    logic [63:0]       word_value;
    logic [15:0]       palette_value;
  } beat_t;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    logic [3:0] bits;
    beat_t      b;
    bit         typed;
    answer_t    ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = MODE_GET;
  logic signed [5:0] in_pos_x = '0;
  logic signed [5:0] in_pos_y = '0;
  logic signed [5:0] in_pos_z = '0;
  logic [15:0] in_block_id = '0;
  logic [9:0]  in_word_index = '0;
  logic [63:0] in_word_value = '0;
  logic [15:0] in_palette_value = '0;
  logic        out_valid;
  logic [15:0] out_result_id;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  // Shadow copy of the store that the predictor keeps in step with the block.
  logic [63:0] shadow_words [DATA_WORDS];
  logic [15:0] shadow_palette [PALETTE_DEPTH];
  logic [8:0]  shadow_pal_count = '0;
  logic [3:0]  shadow_bits = 4'(DEFAULT_BITS);

  answer_t     answers_due [$];
  row_t        directed_rows [$];
  logic [11:0] recent_cells [$];
  logic [15:0] id_pool [8];
  int          quiet_left = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  paletted_packed_block_store #(
    .EDGE         (EDGE),
    .MAX_BITS     (MAX_BITS),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_block_id     (in_block_id),
    .in_word_index   (in_word_index),
    .in_word_value   (in_word_value),
    .in_palette_value(in_palette_value),
    .out_valid       (out_valid),
    .out_result_id   (out_result_id),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Writes one field into the shadow words. When the field runs past the end of its
  // word, only the low bits of the next word that belong to the field are replaced.
  function automatic void put_field(input int unsigned cell_idx, input int unsigned w,
                                    input logic [63:0] v);
    int unsigned bit_at, word, off;
    logic [63:0] mask, hmask, val;
    bit_at = cell_idx * w;
    word   = bit_at / WORD_BITS;
    off    = bit_at % WORD_BITS;
    mask   = (64'd1 << w) - 64'd1;
    val    = v & mask;
    shadow_words[word] = (shadow_words[word] & ~(mask << off)) | (val << off);
    if (off + w > WORD_BITS && word + 1 < DATA_WORDS) begin
      hmask = (64'd1 << (off + w - WORD_BITS)) - 64'd1;
      shadow_words[word + 1] = (shadow_words[word + 1] & ~hmask) | (val >> (WORD_BITS - off));
    end
  endfunction

  // Applies one beat to the shadow store and returns the answer the block must give.
  function automatic answer_t apply_to_store(input beat_t b);
    answer_t     a;
    int unsigned w, cell_idx, bit_at, word, off, cap, found, i;
    logic [63:0] mask, field;
    logic [127:0] pair;
    bit          in_range;
    a.id     = '0;
    a.status = ST_OK;
    // A zero register means the default width; anything past the maximum is clamped.
    if (shadow_bits == 0) w = DEFAULT_BITS;
    else if (shadow_bits > MAX_BITS) w = MAX_BITS;
    else w = shadow_bits;
    in_range = b.x >= 0 && b.x < EDGE && b.y >= 0 && b.y < EDGE && b.z >= 0 && b.z < EDGE;
    cell_idx = in_range ? b.y * EDGE * EDGE + b.z * EDGE + b.x : 0;
    bit_at   = cell_idx * w;
    word     = bit_at / WORD_BITS;
    off      = bit_at % WORD_BITS;
    mask     = (64'd1 << w) - 64'd1;
    case (b.mode)
      MODE_GET: begin
        if (!in_range) begin
          a.status = ST_RANGE;
        end else begin
          pair  = {((word + 1 < DATA_WORDS) ? shadow_words[word + 1] : 64'd0),
                   shadow_words[word]};
          field = 64'(pair >> off) & mask;
          // Direct mode gives the field itself; palette mode maps it, and a field
          // beyond the valid entries reads as id 0.
          if (w >= DIRECT_FROM) a.id = field[15:0];
          else if (field < shadow_pal_count) a.id = shadow_palette[field[7:0]];
        end
      end
      MODE_SET: begin
        if (!in_range) begin
          a.status = ST_RANGE;
        end else if (w >= DIRECT_FROM) begin
          put_field(cell_idx, w, {48'd0, b.block_id});
        end else begin
          cap = 1 << w;
          // An empty palette first gets id 0 at entry 0, so zero fields stay id 0.
          if (shadow_pal_count == 0) begin
            shadow_palette[0] = '0;
            shadow_pal_count  = 9'd1;
          end
          found = PALETTE_DEPTH;
          for (i = 0; i < shadow_pal_count; i++) begin
            if (found == PALETTE_DEPTH && shadow_palette[i] == b.block_id) found = i;
          end
          if (found < cap) begin
            put_field(cell_idx, w, 64'(found));
          end else if (found == PALETTE_DEPTH && shadow_pal_count < cap) begin
            shadow_palette[shadow_pal_count[7:0]] = b.block_id;
            put_field(cell_idx, w, 64'(shadow_pal_count));
            shadow_pal_count = shadow_pal_count + 9'd1;
          end else begin
            // Either the id sits past what the width can address, or there is no room.
            a.status = ST_FULL;
          end
        end
      end
      MODE_LOAD: begin
        if (b.word_index < DATA_WORDS) shadow_words[b.word_index] = b.word_value;
        else a.status = ST_RANGE;
      end
      MODE_APPEND: begin
        if (shadow_pal_count < PALETTE_DEPTH) begin
          shadow_palette[shadow_pal_count[7:0]] = b.palette_value;
          shadow_pal_count = shadow_pal_count + 9'd1;
        end else begin
          a.status = ST_FULL;
        end
      end
      MODE_CLEAR: begin
        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_pal_count = '0;
      end
      default: ;
    endcase
    return a;
  endfunction

  // The sender waits a random gap, bounded by MAX_GAP, before each beat, except in quiet
  // stretches where beats follow back to back.
  function automatic int draw_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 30);
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [15:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return id_pool[$urandom_range(0, 7)];
    if (r < 70) return 16'h0000;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Random beat. Most beats are gets and sets on a small corner of the cube or on
  // cells set lately, so that reads find what was written; the rest are loads,
  // palette appends, rare clears, spare modes and positions out of range.
  function automatic beat_t make_beat(input bit filling);
    beat_t       b;
    int unsigned r, rp;
    int          bad;
    logic [11:0] spot;
    r = $urandom_range(0, 999);
    if (filling) b.mode = MODE_APPEND;
    else if (r < 340) b.mode = MODE_SET;
    else if (r < 660) b.mode = MODE_GET;
    else if (r < 760) b.mode = MODE_LOAD;
    else if (r < 900) b.mode = MODE_APPEND;
    else if (r < 905) b.mode = MODE_CLEAR;
    else if (r < 925) begin
      case ($urandom_range(0, 2))
        0:       b.mode = MODE_SPARE5;
        1:       b.mode = MODE_SPARE6;
        default: b.mode = MODE_SPARE7;
      endcase
    end else b.mode = MODE_GET;

    rp = $urandom_range(0, 99);
    if (rp < 40 && recent_cells.size() > 0)
      spot = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
    else if (rp < 75)
      spot = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
    else
      spot = 12'($urandom);
    b.x = {2'b00, spot[11:8]};
    b.y = {2'b00, spot[7:4]};
    b.z = {2'b00, spot[3:0]};
    if (rp >= 90) begin
      case ($urandom_range(0, 3))
        0:       bad = -1;
        1:       bad = EDGE;
        2:       bad = $urandom_range(EDGE, 31);
        default: bad = -int'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 2))
        0:       b.x = 6'(bad);
        1:       b.y = 6'(bad);
        default: b.z = 6'(bad);
      endcase
    end else if (b.mode == MODE_SET) begin
      recent_cells.insert(recent_cells.size(), spot);
      if (recent_cells.size() > 16) void'(recent_cells.pop_front());
    end

    b.block_id      = pick_id();
    b.palette_value = pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b.word_index = 10'($urandom_range(0, 63));
      5, 6, 7, 8:    b.word_index = 10'($urandom_range(0, DATA_WORDS - 1));
      default:       b.word_index = 10'($urandom_range(DATA_WORDS, 1023));
    endcase
    case ($urandom_range(0, 7))
      0:       b.word_value = '0;
      1:       b.word_value = '1;
      default: b.word_value = {$urandom, $urandom};
    endcase
    return b;
  endfunction

  function automatic void plan_row(input int bits, input logic [2:0] mode, input int x,
                                   input int y, input int z, input int data,
                                   input logic [63:0] wv, input bit typed,
                                   input int exp_id, input logic [1:0] exp_st);
    row_t rw;
    rw.bits            = 4'(bits);
    rw.b.mode          = mode;
    rw.b.x             = 6'(x);
    rw.b.y             = 6'(y);
    rw.b.z             = 6'(z);
    rw.b.block_id      = 16'(data);
    rw.b.word_index    = 10'(data);
    rw.b.palette_value = 16'(data);
    rw.b.word_value    = wv;
    rw.typed           = typed;
    rw.ans.id          = 16'(exp_id);
    rw.ans.status      = exp_st;
    directed_rows.insert(directed_rows.size(), rw);
  endfunction

  // Presents one beat and holds it until the block takes it. Entered just after a
  // falling edge and left just after one. The predictor runs at the accepting edge;
  // a typed answer, where given, stands in for the predicted one.
  task automatic push_beat(input beat_t b, input bit typed, input answer_t given);
    answer_t predicted;
    int      gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start            <= 1'b1;
    in_mode          <= b.mode;
    in_pos_x         <= b.x;
    in_pos_y         <= b.y;
    in_pos_z         <= b.z;
    in_block_id      <= b.block_id;
    in_word_index    <= b.word_index;
    in_word_value    <= b.word_value;
    in_palette_value <= b.palette_value;
    do @(posedge clk); while (busy);
    predicted = apply_to_store(b);
    answers_due.insert(answers_due.size(), typed ? given : predicted);
    @(negedge clk);
  endtask

  // Lowers start and waits until every expected beat has come and the block is idle.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0 || busy);
    @(negedge clk);
  endtask

  // The width register is only written while the block is idle.
  task automatic set_field_width(input logic [3:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we      <= 1'b0;
    shadow_bits = v;
  endtask

  initial begin : stimulus
    row_t rw;
    int   fill_left;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows. After reset every field reads as id 0, since the palette is empty.
    plan_row(4, MODE_GET, 0, 0, 0, 0, '0, 1, 0, ST_OK);
    plan_row(4, MODE_GET, -1, 0, 0, 0, '0, 1, 0, ST_RANGE);
    plan_row(4, MODE_GET, 0, 16, 0, 0, '0, 1, 0, ST_RANGE);
    // The first set on an empty palette seeds entry 0 with id 0, then appends.
    plan_row(4, MODE_SET, 15, 15, 15, 'hFFFF, '0, 1, 0, ST_OK);
    plan_row(4, MODE_GET, 15, 15, 15, 0, '0, 0, 0, ST_OK);
    plan_row(4, MODE_SET, 0, 0, -1, 5, '0, 1, 0, ST_RANGE);
    plan_row(4, MODE_APPEND, 0, 0, 0, 'h1234, '0, 1, 0, ST_OK);
    plan_row(4, MODE_LOAD, 0, 0, 0, DATA_WORDS - 1, '1, 1, 0, ST_OK);
    plan_row(4, MODE_LOAD, 0, 0, 0, DATA_WORDS, '1, 1, 0, ST_RANGE);
    plan_row(4, MODE_LOAD, 0, 0, 0, 1023, '0, 1, 0, ST_RANGE);
    // Word 255 holds the last sixteen cells at four bits; all ones there gives the
    // last cell a palette index past the valid entries.
    plan_row(4, MODE_LOAD, 0, 0, 0, 255, '1, 1, 0, ST_OK);
    plan_row(4, MODE_GET, 15, 15, 15, 0, '0, 0, 0, ST_OK);
    plan_row(4, MODE_SPARE5, 3, 3, 3, 7, '1, 1, 0, ST_OK);
    plan_row(4, MODE_SPARE7, 3, 3, 3, 7, '1, 1, 0, ST_OK);
    plan_row(4, MODE_CLEAR, 0, 0, 0, 0, '0, 1, 0, ST_OK);
    // With one bit per block the palette holds two ids, so a third id is refused.
    plan_row(1, MODE_SET, 0, 0, 0, 'h0077, '0, 0, 0, ST_OK);
    plan_row(1, MODE_SET, 1, 0, 0, 'h0088, '0, 1, 0, ST_FULL);
    plan_row(1, MODE_GET, 0, 0, 0, 0, '0, 0, 0, ST_OK);
    // A zero register behaves as the default width.
    plan_row(0, MODE_SET, 5, 0, 0, 0, '0, 0, 0, ST_OK);
    // Cell 21 at three bits starts at bit 63 and straddles two words.
    plan_row(3, MODE_SET, 5, 0, 1, 'h4444, '0, 0, 0, ST_OK);
    plan_row(3, MODE_GET, 5, 0, 1, 0, '0, 0, 0, ST_OK);
    // Width 15 clamps to 14: a direct id cut to 14 bits, straddling at bit 56.
    plan_row(15, MODE_SET, 4, 0, 0, 'hFFFF, '0, 0, 0, ST_OK);
    plan_row(15, MODE_GET, 4, 0, 0, 0, '0, 0, 0, ST_OK);
    plan_row(14, MODE_GET, 3, 0, 0, 0, '0, 0, 0, ST_OK);
    plan_row(9, MODE_SET, 15, 15, 15, 'hFFFF, '0, 0, 0, ST_OK);
    plan_row(9, MODE_GET, 15, 15, 15, 0, '0, 0, 0, ST_OK);

    foreach (directed_rows[i]) begin
      rw = directed_rows[i];
      if (rw.bits != shadow_bits) set_field_width(rw.bits);
      push_beat(rw.b, rw.typed, rw.ans);
    end

    // Random phases, one width each. Up to half the id pool changes per phase, so later
    // phases still hit ids that earlier ones put in the palette.
    for (int p = 0; p < PHASES; p++) begin
      set_field_width(PHASE_WIDTHS[47 - 4 * p -: 4]);
      for (int k = 0; k < 4; k++) id_pool[$urandom_range(0, 7)] = 16'($urandom);
      // At width 8 the phase opens with appends until three run past the palette depth,
      // so that both a full palette and refused appends are seen.
      fill_left = (shadow_bits == 8) ? PALETTE_DEPTH - int'(shadow_pal_count) + 3 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE + fill_left; n++)
        push_beat(make_beat(n < fill_left), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("paletted_packed_block_store_test: done, clean");
    end else begin
      $display("paletted_packed_block_store_test: done, errors");
    end
    $finish;
  end

  // Every result beat is matched against the oldest answer still due.
  always @(posedge clk) begin : result_check
    answer_t due;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result beat: result_id %h, status %0d", out_result_id, out_status);
        mismatches++;
      end else begin
        due = answers_due.pop_front();
        if (out_result_id !== due.id) begin
          $error("result_id: expected %h, got %h", due.id, out_result_id);
          mismatches++;
        end
        if (out_status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("paletted_packed_block_store_test: done, errors");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ppbs_pkg.sv
rtl/core/ppbs_ram.sv
rtl/core/ppbs_field.sv
rtl/core/paletted_packed_block_store.sv
test/paletted_packed_block_store_test.sv
